[hdl/ascii_range_median_filter_assert.svh]
// ----------------------------------------------------------------------------
// ascii_range_median_filter_assert.svh
// Assertion macros used by the range median filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASCII_RANGE_MEDIAN_FILTER_ASSERT_SVH
`define ASCII_RANGE_MEDIAN_FILTER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ARFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ARFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/arfm_pkg.sv]
// ----------------------------------------------------------------------------
// arfm_pkg
// Types and constants of the ASCII range median filter.
// ----------------------------------------------------------------------------
package arfm_pkg;

    // Field and port widths
    localparam int BYTE_W      = 8;
    localparam int DIST_W      = 14;
    localparam int DIGIT_CNT_W = 3;
    localparam int WIN_SIZE_W  = 5;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int ACC_PROD_W  = DIST_W + 4;

    localparam int WINDOW_MAX_DEF = 16;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 1'd1;

    // Register reset values and limits
    localparam logic [DIGIT_CNT_W-1:0] DIGIT_COUNT_RST = 3'd3;
    localparam logic [WIN_SIZE_W-1:0]  WINDOW_SIZE_RST = 5'd5;
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_MIN      = 3'd1;
    localparam logic [DIGIT_CNT_W-1:0] DIGITS_MAX      = 3'd4;

    // ASCII codes
    localparam logic [BYTE_W-1:0] MARKER     = 8'h52;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    localparam logic [ACC_PROD_W-1:0] DEC_BASE = 18'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_CHECK,
        ST_OUT
    } state_t;

endpackage

[hdl/arfm_ram.sv]
// ----------------------------------------------------------------------------
// arfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arfm_ram #(
    parameter int DATA_W = 14,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/ascii_range_median_filter.sv]
// ----------------------------------------------------------------------------
// ascii_range_median_filter
// Decodes 'R'-prefixed ASCII range readings and emits a sliding-window median.
// ----------------------------------------------------------------------------
// Each accepted byte is a transaction on the s_ side. Bytes that are not part
// of a reading and digit bytes are taken in the idle state: a reading is
// decoded on the fly and its value is written into the window memory with its
// last byte. An 'R' marker that arrives once the window is full starts a rank
// search, and no further byte is taken until its result sits in the output
// register. The search walks candidates in slot order; each candidate takes
// one memory read of the candidate, ws compare reads through the single read
// port of the compare copy and one decision. The window lives in two
// identical copies of a small RAM so that the candidate and the compared entry
// can be read in the same cycle. The result is the value at rank ws/2 of the
// window sorted in descending order, found as the candidate with at most ws/2
// greater entries and more than ws/2 entries not smaller. The output register
// lets a new byte be taken while a result waits on m_tready. Configuration
// writes are applied at once; write them only while idle.
// ----------------------------------------------------------------------------
module ascii_range_median_filter #(
    parameter int WINDOW_MAX = arfm_pkg::WINDOW_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [arfm_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    // Median results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [arfm_pkg::M_TDATA_W-1:0]   m_tdata,   // [13:0] distance, [15:14] zero
    // Configuration writes
    input  logic                             cfg_we,
    input  logic [arfm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [arfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import arfm_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    // Configuration registers
    logic [DIGIT_CNT_W-1:0] digit_count_reg;
    logic [WIN_SIZE_W-1:0]  window_size_reg;

    // Control state
    state_t                 state_reg, state_next;
    logic [DIGIT_CNT_W-1:0] digits_left_reg, digits_left_next;
    logic [DIST_W-1:0]      acc_reg, acc_next;
    logic                   stopped_reg, stopped_next;
    logic [CW-1:0]          fill_count_reg, fill_count_next;
    logic [AW-1:0]          oldest_reg, oldest_next;
    logic [CW-1:0]          win_reg, win_next;
    logic [CW-1:0]          cand_reg, cand_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic [CW-1:0]          gt_reg, gt_next;
    logic [CW-1:0]          ge_reg, ge_next;
    logic                   m_tvalid_reg;
    logic [DIST_W-1:0]      dist_reg;

    // Memory ports
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DIST_W-1:0] wr_data;
    logic              rd_en_a, rd_en_b;
    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    logic [DIST_W-1:0] rd_data_a, rd_data_b;

    // Datapath helpers
    logic                   in_fire;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   is_digit;
    logic [ACC_PROD_W-1:0]  acc_prod;
    logic [DIST_W-1:0]      acc_step;
    logic [CW-1:0]          ws_eff;
    logic [DIGIT_CNT_W-1:0] digits_eff;
    logic [AW-1:0]          slot;
    logic [CW-1:0]          slot_inc;
    logic [CW-1:0]          scan_inc;
    logic [CW-1:0]          rank_k;
    logic                   out_load;

    assign in_fire  = s_tvalid && s_tready;
    assign rx_byte  = s_tdata[BYTE_W-1:0];
    assign is_digit = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);

    // Shift one decimal digit into the accumulator, wrap to the field width.
    assign acc_prod = ACC_PROD_W'(acc_reg) * DEC_BASE + ACC_PROD_W'(rx_byte - ASCII_ZERO);
    assign acc_step = acc_prod[DIST_W-1:0];

    // Clamp the window size to 1..WINDOW_MAX.
    always_comb begin
        if (window_size_reg == '0) begin
            ws_eff = CW'(1);
        end else if (int'(window_size_reg) > WINDOW_MAX) begin
            ws_eff = CW'(WINDOW_MAX);
        end else begin
            ws_eff = CW'(window_size_reg);
        end
    end

    // Clamp the digit count to 1..4.
    always_comb begin
        if (digit_count_reg < DIGITS_MIN) begin
            digits_eff = DIGITS_MIN;
        end else if (digit_count_reg > DIGITS_MAX) begin
            digits_eff = DIGITS_MAX;
        end else begin
            digits_eff = digit_count_reg;
        end
    end

    // Replacement slot: an oldest pointer outside a shrunk window wraps to 0.
    assign slot     = (CW'(oldest_reg) >= ws_eff) ? '0 : oldest_reg;
    assign slot_inc = CW'(slot) + CW'(1);
    assign scan_inc = scan_reg + CW'(1);
    assign rank_k   = win_reg >> 1;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= DIGIT_COUNT_RST;
            window_size_reg <= WINDOW_SIZE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DIGIT_COUNT: digit_count_reg <= cfg_wdata[DIGIT_CNT_W-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_wdata[WIN_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state: byte parsing in idle, then the rank search sequence.
    always_comb begin
        state_next       = state_reg;
        digits_left_next = digits_left_reg;
        acc_next         = acc_reg;
        stopped_next     = stopped_reg;
        fill_count_next  = fill_count_reg;
        oldest_next      = oldest_reg;
        win_next         = win_reg;
        cand_next        = cand_reg;
        scan_next        = scan_reg;
        gt_next          = gt_reg;
        ge_next          = ge_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = acc_reg;
        rd_en_a          = 1'b0;
        rd_addr_a        = cand_reg[AW-1:0];
        rd_en_b          = 1'b0;
        rd_addr_b        = '0;
        out_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (digits_left_reg != '0) begin
                        // Byte inside a reading: decode until the first non-digit.
                        if (!stopped_reg && is_digit) begin
                            acc_next = acc_step;
                        end else begin
                            stopped_next = 1'b1;
                        end
                        digits_left_next = digits_left_reg - DIGIT_CNT_W'(1);
                        wr_data = acc_next;
                        if (digits_left_reg == DIGIT_CNT_W'(1)) begin
                            // Last byte: store the reading.
                            wr_en = 1'b1;
                            if (fill_count_reg < ws_eff) begin
                                wr_addr         = fill_count_reg[AW-1:0];
                                fill_count_next = fill_count_reg + CW'(1);
                            end else begin
                                wr_addr     = slot;
                                oldest_next = (slot_inc >= ws_eff) ? '0 : slot_inc[AW-1:0];
                            end
                        end
                    end else if (rx_byte == MARKER) begin
                        digits_left_next = digits_eff;
                        acc_next         = '0;
                        stopped_next     = 1'b0;
                        if (fill_count_reg >= ws_eff) begin
                            // Window full: start the search over the first ws slots.
                            win_next   = ws_eff;
                            cand_next  = '0;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end

            ST_LOAD: begin
                // Fetch the candidate and the first compared entry.
                rd_en_a    = 1'b1;
                rd_addr_a  = cand_reg[AW-1:0];
                rd_en_b    = 1'b1;
                rd_addr_b  = '0;
                scan_next  = '0;
                gt_next    = '0;
                ge_next    = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN: begin
                gt_next = gt_reg + CW'(rd_data_b > rd_data_a);
                ge_next = ge_reg + CW'(rd_data_b >= rd_data_a);
                if (scan_reg == win_reg - CW'(1)) begin
                    state_next = ST_CHECK;
                end else begin
                    rd_en_b   = 1'b1;
                    rd_addr_b = scan_inc[AW-1:0];
                    scan_next = scan_inc;
                end
            end

            ST_CHECK: begin
                if ((gt_reg <= rank_k) && (rank_k < ge_reg)) begin
                    state_next = ST_OUT;
                end else begin
                    cand_next  = cand_reg + CW'(1);
                    state_next = ST_LOAD;
                end
            end

            ST_OUT: begin
                // Hold the candidate until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            digits_left_reg <= '0;
            acc_reg         <= '0;
            stopped_reg     <= 1'b0;
            fill_count_reg  <= '0;
            oldest_reg      <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            digits_left_reg <= digits_left_next;
            acc_reg         <= acc_next;
            stopped_reg     <= stopped_next;
            fill_count_reg  <= fill_count_next;
            oldest_reg      <= oldest_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Search and output payload registers
    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        cand_reg <= cand_next;
        scan_reg <= scan_next;
        gt_reg   <= gt_next;
        ge_reg   <= ge_next;
        if (out_load) begin
            dist_reg <= rd_data_a;
        end
    end

    // Two copies of the window: candidate port and compare port.
    arfm_ram #(
        .DATA_W (DIST_W),
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (AW)
    ) u_win_cand (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en_a),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    arfm_ram #(
        .DATA_W (DIST_W),
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (AW)
    ) u_win_cmp (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en_b),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(dist_reg);

`include "ascii_range_median_filter_assert.svh"

    // The window is not written while a search runs.
    `ARFM_ASSERT_NEXT(a_fill_hold, state_reg != ST_IDLE, $stable(fill_count_reg), "fill changed during search")
    // Some candidate inside the window always meets the rank test.
    `ARFM_ASSERT_NOW(a_cand_in_window, state_reg == ST_LOAD, cand_reg < win_reg, "candidate beyond window")
    // Greater count never exceeds the not-smaller count.
    `ARFM_ASSERT_NOW(a_count_order, state_reg == ST_CHECK, gt_reg <= ge_reg, "rank counts out of order")
    // A new result only comes out of a finished search.
    `ARFM_ASSERT_NEXT(a_out_source, !m_tvalid_reg, !m_tvalid_reg || ($past(state_reg) == ST_OUT), "result without search")

endmodule
